@@ hdl/tpa_pkg.sv @@
package tpa_pkg;

  localparam int PACKET_BYTES = 45;
  localparam int POS_W = 6;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);
  localparam logic [4:0] TEXT_ROW_MAX = 5'd24;

  localparam logic [7:0] RUN_IN = 8'h55;
  localparam logic [7:0] FRAMING = 8'h27;
  localparam logic [6:0] SPACE = 7'h20;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_DISPATCH = 5'd0;
  localparam step_t STEP_TEXT_CHK = 5'd14;
  localparam step_t STEP_TEXT = 5'd15;
  localparam step_t STEP_PAD = 5'd16;
  localparam step_t STEP_IDLE = 5'd17;

  typedef enum logic [3:0] {
    SRC_RUNIN,
    SRC_FRAMING,
    SRC_ADDR1,
    SRC_ADDR2,
    SRC_PU,
    SRC_PT,
    SRC_S1,
    SRC_S2,
    SRC_S3,
    SRC_S4,
    SRC_ZERO,
    SRC_TEXT,
    SRC_SPACE
  } src_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ALWAYS,
    EMIT_TEXT,
    EMIT_OPEN
  } emit_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_NOT_FIRST,
    COND_ROW_NZ,
    COND_NOT_OPEN,
    COND_NOT_LAST,
    COND_PAD_MORE
  } cond_t;

  typedef struct packed {
    src_t  src;
    emit_t emit;
    cond_t cond;
    logic  start;
    step_t target;
  } ctrl_t;

  function automatic logic [7:0] ham84(input logic [3:0] nib);
    logic [7:0] code;
    case (nib)
      4'h0: code = 8'h15;
      4'h1: code = 8'h02;
      4'h2: code = 8'h49;
      4'h3: code = 8'h5E;
      4'h4: code = 8'h64;
      4'h5: code = 8'h73;
      4'h6: code = 8'h38;
      4'h7: code = 8'h2F;
      4'h8: code = 8'hD0;
      4'h9: code = 8'hC7;
      4'hA: code = 8'h8C;
      4'hB: code = 8'h9B;
      4'hC: code = 8'hA1;
      4'hD: code = 8'hB6;
      4'hE: code = 8'hFD;
      default: code = 8'hEA;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] odd_parity(input logic [6:0] ch);
    return {~^ch, ch};
  endfunction

endpackage

@@ hdl/tpa_ucode_rom.sv @@
module tpa_ucode_rom
  import tpa_pkg::*;
(
  input  step_t step,
  output ctrl_t ctrl
);

  always_comb begin
    ctrl = '{src: SRC_SPACE, emit: EMIT_NONE, cond: COND_NEXT, start: 1'b0,
             target: STEP_IDLE};
    case (step)
      STEP_DISPATCH: begin
        ctrl.start = 1'b1;
        ctrl.cond = COND_NOT_FIRST;
        ctrl.target = STEP_TEXT_CHK;
      end
      5'd1: begin ctrl.src = SRC_RUNIN; ctrl.emit = EMIT_ALWAYS; end
      5'd2: begin ctrl.src = SRC_RUNIN; ctrl.emit = EMIT_ALWAYS; end
      5'd3: begin ctrl.src = SRC_FRAMING; ctrl.emit = EMIT_ALWAYS; end
      5'd4: begin ctrl.src = SRC_ADDR1; ctrl.emit = EMIT_ALWAYS; end
      5'd5: begin
        ctrl.src = SRC_ADDR2;
        ctrl.emit = EMIT_ALWAYS;
        ctrl.cond = COND_ROW_NZ;
        ctrl.target = STEP_TEXT_CHK;
      end
      5'd6: begin ctrl.src = SRC_PU; ctrl.emit = EMIT_ALWAYS; end
      5'd7: begin ctrl.src = SRC_PT; ctrl.emit = EMIT_ALWAYS; end
      5'd8: begin ctrl.src = SRC_S1; ctrl.emit = EMIT_ALWAYS; end
      5'd9: begin ctrl.src = SRC_S2; ctrl.emit = EMIT_ALWAYS; end
      5'd10: begin ctrl.src = SRC_S3; ctrl.emit = EMIT_ALWAYS; end
      5'd11: begin ctrl.src = SRC_S4; ctrl.emit = EMIT_ALWAYS; end
      5'd12: begin ctrl.src = SRC_ZERO; ctrl.emit = EMIT_ALWAYS; end
      5'd13: begin ctrl.src = SRC_ZERO; ctrl.emit = EMIT_ALWAYS; end
      STEP_TEXT_CHK: begin
        ctrl.cond = COND_NOT_OPEN;
        ctrl.target = STEP_IDLE;
      end
      STEP_TEXT: begin
        ctrl.src = SRC_TEXT;
        ctrl.emit = EMIT_TEXT;
        ctrl.cond = COND_NOT_LAST;
        ctrl.target = STEP_IDLE;
      end
      STEP_PAD: begin
        ctrl.src = SRC_SPACE;
        ctrl.emit = EMIT_OPEN;
        ctrl.cond = COND_PAD_MORE;
        ctrl.target = STEP_PAD;
      end
      default: ctrl.target = STEP_IDLE;
    endcase
  end

endmodule

@@ hdl/tpa_byte_gen.sv @@
module tpa_byte_gen
  import tpa_pkg::*;
(
  input  src_t        src,
  input  logic [6:0]  text,
  input  logic [2:0]  magazine,
  input  logic [4:0]  row,
  input  logic [7:0]  page_number,
  input  logic [13:0] subcode,
  output logic [7:0]  data
);

  always_comb begin
    case (src)
      SRC_RUNIN:   data = RUN_IN;
      SRC_FRAMING: data = FRAMING;
      SRC_ADDR1:   data = ham84({row[0], magazine});
      SRC_ADDR2:   data = ham84(row[4:1]);
      SRC_PU:      data = ham84(page_number[3:0]);
      SRC_PT:      data = ham84(page_number[7:4]);
      SRC_S1:      data = ham84(subcode[3:0]);
      SRC_S2:      data = ham84({1'b0, subcode[6:4]});
      SRC_S3:      data = ham84(subcode[11:8]);
      SRC_S4:      data = ham84({2'b00, subcode[13:12]});
      SRC_ZERO:    data = ham84(4'h0);
      SRC_TEXT:    data = odd_parity(text);
      default:     data = odd_parity(SPACE);
    endcase
  end

endmodule

@@ hdl/teletext_packet_assembler.sv @@
// Teletext packet assembler. Each transfer on the input channel is one item
// of a packet request: an item with first_item set starts a 45-byte packet
// (run-in, framing code, Hamming 8/4 address and, for row 0, page and subcode
// groups), an item with has_text adds one odd-parity text byte if the packet
// is open and its row is at most 24; an item with last_item pads the rest
// of the packet with spaces. A control word table steps through one step per
// cycle while the output side does not stall, each output byte taking one
// step after dispatch and checks; the next item is taken once the program for
// the current one has finished and returned to idle.
module teletext_packet_assembler
  import tpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        has_text,
  input  logic        first_item,
  input  logic        last_item,
  input  logic [2:0]  magazine,
  input  logic [4:0]  row,
  input  logic [7:0]  page_number,
  input  logic [13:0] subcode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  packet_byte,
  output logic [5:0]  byte_index,
  output logic        last_byte
);

  step_t             step;
  step_t             step_next;
  ctrl_t             ctrl;
  logic [POS_W-1:0]  byte_position;
  logic [4:0]        latched_row;
  logic              packet_open;
  logic [6:0]        text;
  logic              text_valid;
  logic              first;
  logic              last;
  logic [2:0]        mag;
  logic [7:0]        page;
  logic [13:0]       sub;
  logic [7:0]        gen_byte;
  logic              emit_now;
  logic              out_free;
  logic              advance;
  logic              jump;

  tpa_ucode_rom u_rom (
    .step (step),
    .ctrl (ctrl)
  );

  tpa_byte_gen u_gen (
    .src         (ctrl.src),
    .text        (text),
    .magazine    (mag),
    .row         (latched_row),
    .page_number (page),
    .subcode     (sub),
    .data        (gen_byte)
  );

  assign in_ready = (step == STEP_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (ctrl.emit)
      EMIT_ALWAYS: emit_now = 1'b1;
      EMIT_TEXT:   emit_now = text_valid && (latched_row <= TEXT_ROW_MAX);
      EMIT_OPEN:   emit_now = packet_open;
      default:     emit_now = 1'b0;
    endcase
    if (step == STEP_IDLE) begin
      emit_now = 1'b0;
    end
  end

  assign advance = (step != STEP_IDLE) && (!emit_now || out_free);

  always_comb begin
    case (ctrl.cond)
      COND_NOT_FIRST: jump = !first;
      COND_ROW_NZ:    jump = (latched_row != 5'd0);
      COND_NOT_OPEN:  jump = !packet_open;
      COND_NOT_LAST:  jump = !last;
      COND_PAD_MORE:  jump = packet_open && (byte_position != LAST_POS);
      default:        jump = 1'b0;
    endcase
    step_next = jump ? ctrl.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
      packet_open <= 1'b0;
      byte_position <= '0;
      latched_row <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        step <= STEP_DISPATCH;
        if (first_item) begin
          latched_row <= row;
        end
      end else if (advance) begin
        step <= step_next;
        if (ctrl.start && first) begin
          packet_open <= 1'b1;
          byte_position <= '0;
        end
        if (emit_now) begin
          out_valid <= 1'b1;
          byte_position <= byte_position + 1'b1;
          if (byte_position == LAST_POS) begin
            packet_open <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      text <= text_byte[6:0];
      text_valid <= has_text;
      first <= first_item;
      last <= last_item;
      if (first_item) begin
        mag <= magazine;
        page <= page_number;
        sub <= subcode;
      end
    end
    if (advance && emit_now) begin
      packet_byte <= gen_byte;
      byte_index <= byte_position;
      last_byte <= (byte_position == LAST_POS);
    end
  end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  import tpa_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int ITEMS_PER_PHASE = 65;

  typedef struct {
    logic [7:0]  text;
    logic        has;
    logic        first;
    logic        last;
    logic [2:0]  mag;
    logic [4:0]  row;
    logic [7:0]  page;
    logic [13:0] sub;
  } req_t;

  typedef struct {
    logic [7:0] code;
    logic [5:0] idx;
    logic       fin;
  } coded_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = '0;
  logic        has_text = 1'b0;
  logic        first_item = 1'b0;
  logic        last_item = 1'b0;
  logic [2:0]  magazine = '0;
  logic [4:0]  row = '0;
  logic [7:0]  page_number = '0;
  logic [13:0] subcode = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  packet_byte;
  logic [5:0]  byte_index;
  logic        last_byte;

  req_t   pending_reqs[$];
  coded_t expected_bytes[$];

  int phase = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 72;
  int errors = 0;
  int idle_cycles = 0;
  int item_count = 0;
  int hold_count = 0;

  // packet state of the predictor
  int         enc_pos = 0;
  logic [4:0] enc_row = '0;
  bit         enc_open = 1'b0;

  teletext_packet_assembler u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .text_byte(text_byte), .has_text(has_text),
    .first_item(first_item), .last_item(last_item),
    .magazine(magazine), .row(row),
    .page_number(page_number), .subcode(subcode),
    .out_valid(out_valid), .out_ready(out_ready),
    .packet_byte(packet_byte), .byte_index(byte_index), .last_byte(last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] hamming_code(input logic [3:0] nib);
    logic [7:0] c;
    case (nib)
      4'h0: c = 8'h15;
      4'h1: c = 8'h02;
      4'h2: c = 8'h49;
      4'h3: c = 8'h5E;
      4'h4: c = 8'h64;
      4'h5: c = 8'h73;
      4'h6: c = 8'h38;
      4'h7: c = 8'h2F;
      4'h8: c = 8'hD0;
      4'h9: c = 8'hC7;
      4'hA: c = 8'h8C;
      4'hB: c = 8'h9B;
      4'hC: c = 8'hA1;
      4'hD: c = 8'hB6;
      4'hE: c = 8'hFD;
      default: c = 8'hEA;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] parity_char(input logic [7:0] ch);
    logic [6:0] low;
    low = ch[6:0];
    return (^low) ? {1'b0, low} : {1'b1, low};
  endfunction

  task put_coded(input logic [7:0] v);
    coded_t c;
    if (!enc_open || enc_pos >= PACKET_BYTES)
      return;
    c.code = v;
    c.idx = 6'(enc_pos);
    c.fin = (enc_pos == PACKET_BYTES - 1);
    expected_bytes.push_back(c);
    enc_pos++;
    if (enc_pos >= PACKET_BYTES)
      enc_open = 1'b0;
  endtask

  task encode_request(input req_t r);
    if (r.first) begin
      enc_open = 1'b1;
      enc_pos = 0;
      enc_row = r.row;
      put_coded(RUN_IN);
      put_coded(RUN_IN);
      put_coded(FRAMING);
      put_coded(hamming_code({r.row[0], r.mag}));
      put_coded(hamming_code(r.row[4:1]));
      if (r.row == 5'd0) begin
        put_coded(hamming_code(r.page[3:0]));
        put_coded(hamming_code(r.page[7:4]));
        put_coded(hamming_code(r.sub[3:0]));
        put_coded(hamming_code({1'b0, r.sub[6:4]}));
        put_coded(hamming_code(r.sub[11:8]));
        put_coded(hamming_code({2'b00, r.sub[13:12]}));
        put_coded(hamming_code(4'h0));
        put_coded(hamming_code(4'h0));
      end
    end
    if (!enc_open)
      return;
    if (r.has && enc_row <= TEXT_ROW_MAX)
      put_coded(parity_char(r.text));
    if (r.last) begin
      while (enc_open)
        put_coded(parity_char({1'b0, SPACE}));
      enc_pos = 0;
    end
  endtask

  task add_req(input logic [7:0] text, input logic has, input logic first,
               input logic last, input logic [2:0] mag, input logic [4:0] rw,
               input logic [7:0] page, input logic [13:0] sub);
    req_t r;
    r.text = text;
    r.has = has;
    r.first = first;
    r.last = last;
    r.mag = mag;
    r.row = rw;
    r.page = page;
    r.sub = sub;
    pending_reqs.push_back(r);
    item_count++;
  endtask

  function automatic logic [4:0] pick_row();
    if ($urandom_range(0, 3) == 0)
      return 5'd0;
    if ($urandom_range(0, 7) == 0)
      return 5'($urandom_range(25, 31));
    return 5'($urandom_range(1, 24));
  endfunction

  task gen_packet(input logic [4:0] rw, input int n, input bit closed);
    for (int i = 0; i < n; i++)
      add_req(8'($urandom_range(0, 255)), $urandom_range(0, 9) != 0, i == 0,
              closed && (i == n - 1), 3'($urandom_range(0, 7)),
              (i == 0) ? rw : 5'($urandom_range(0, 31)),
              8'($urandom_range(0, 255)), 14'($urandom_range(0, 16383)));
  endtask

  task gen_traffic(input int quota);
    int n;
    int stop_at;
    bit closed;
    stop_at = item_count + quota;
    while (item_count < stop_at) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 46) : $urandom_range(1, 12);
      closed = $urandom_range(0, 9) != 0;
      gen_packet(pick_row(), n, closed);
      // stray item with no packet open
      if (closed && $urandom_range(0, 7) == 0)
        add_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                14'($urandom_range(0, 16383)));
    end
  endtask

  task wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin : drive_inputs
    req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        text_byte <= nxt.text;
        has_text <= nxt.has;
        first_item <= nxt.first;
        last_item <= nxt.last;
        magazine <= nxt.mag;
        row <= nxt.row;
        page_number <= nxt.page;
        subcode <= nxt.sub;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin : drive_ready
    if (rst) begin
      out_ready <= 1'b0;
    end else if (phase == 2 && hold_count < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_count = hold_count + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : check_outputs
    req_t   seen;
    coded_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.text = text_byte;
        seen.has = has_text;
        seen.first = first_item;
        seen.last = last_item;
        seen.mag = magazine;
        seen.row = row;
        seen.page = page_number;
        seen.sub = subcode;
        encode_request(seen);
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte %h at index %0d", packet_byte, byte_index);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (packet_byte !== want.code) begin
            $error("packet_byte: expected %h, got %h", want.code, packet_byte);
            errors++;
          end
          if (byte_index !== want.idx) begin
            $error("byte_index: expected %0d, got %0d", want.idx, byte_index);
            errors++;
          end
          if (last_byte !== want.fin) begin
            $error("last_byte: expected %b, got %b", want.fin, last_byte);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[teletext_packet_assembler] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // header with all fields at minimum, no text
    add_req(8'h00, 1'b0, 1'b1, 1'b1, 3'd0, 5'd0, 8'h00, 14'h0000);
    // header with all fields at maximum, high-bit text
    add_req(8'hFF, 1'b1, 1'b1, 1'b0, 3'd7, 5'd0, 8'hFF, 14'h3FFF);
    add_req(8'h80, 1'b1, 1'b0, 1'b0, 3'd7, 5'd31, 8'hFF, 14'h3FFF);
    add_req(8'h7F, 1'b0, 1'b0, 1'b1, 3'd0, 5'd0, 8'h00, 14'h0000);
    // no packet open: ignored
    add_req(8'h41, 1'b1, 1'b0, 1'b1, 3'd3, 5'd5, 8'h12, 14'h1234);
    add_req(8'h42, 1'b1, 1'b0, 1'b0, 3'd4, 5'd6, 8'h34, 14'h2345);
    // filler row, text dropped
    add_req(8'h41, 1'b1, 1'b1, 1'b0, 3'd2, 5'd31, 8'h56, 14'h0AAA);
    add_req(8'h42, 1'b1, 1'b0, 1'b1, 3'd5, 5'd0, 8'h78, 14'h1555);
    // first row without text
    add_req(8'h55, 1'b1, 1'b1, 1'b1, 3'd5, 5'd25, 8'h9A, 14'h2AAA);
    // last text row
    add_req(8'h7F, 1'b1, 1'b1, 1'b0, 3'd6, 5'd24, 8'hBC, 14'h3555);
    add_req(8'h01, 1'b1, 1'b0, 1'b0, 3'd1, 5'd3, 8'hDE, 14'h0F0F);
    // abandon open packet with a new one
    add_req(8'h00, 1'b1, 1'b1, 1'b0, 3'd1, 5'd1, 8'h21, 14'h30F0);
    add_req(8'hAA, 1'b1, 1'b0, 1'b0, 3'd2, 5'd2, 8'h43, 14'h0333);
    add_req(8'h20, 1'b0, 1'b0, 1'b1, 3'd3, 5'd4, 8'h65, 14'h3CCC);
    add_req(8'hD5, 1'b1, 1'b1, 1'b1, 3'd4, 5'd16, 8'h87, 14'h1111);
    add_req(8'h3C, 1'b1, 1'b1, 1'b1, 3'd3, 5'd30, 8'hA9, 14'h2222);
    // overflow of header text and row text
    gen_packet(5'd0, 36, 1'b1);
    gen_packet(5'd12, 46, 1'b1);
    gen_traffic(ITEMS_PER_PHASE);
    wait_drained();

    phase = 1;
    send_idle_pct = 72;
    recv_idle_pct = 35;
    gen_traffic(ITEMS_PER_PHASE);
    wait_drained();

    phase = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_traffic(ITEMS_PER_PHASE);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0)
      $display("[teletext_packet_assembler] OK");
    else
      $display("[teletext_packet_assembler] ERROR");
    $finish;
  end

endmodule
